/* design/radar_target_frame_parser_unit_defines.svh */
// ----------------------------------------------------------------------------
// Radar target frame parser assertion macros
// Shared concurrent assertion forms for the parser block.
// ----------------------------------------------------------------------------
`ifndef RADAR_TARGET_FRAME_PARSER_UNIT_DEFINES_SVH
`define RADAR_TARGET_FRAME_PARSER_UNIT_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define RTFP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every rising clock edge outside reset.
`define RTFP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* design/rtfp_pkg.sv */
// ----------------------------------------------------------------------------
// rtfp_pkg
// Frame constants, byte positions and the result type of the frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rtfp_pkg;

  localparam int unsigned POS_W = 4;

  localparam logic [7:0]  SYNC_BYTE = 8'hAA;
  localparam logic [15:0] ID_STATUS = 16'h070B;
  localparam logic [15:0] ID_TARGET = 16'h070C;

  // byte positions inside a frame
  localparam logic [POS_W-1:0] POS_HDR0     = 4'd0;
  localparam logic [POS_W-1:0] POS_HDR1     = 4'd1;
  localparam logic [POS_W-1:0] POS_ID_LO    = 4'd2;
  localparam logic [POS_W-1:0] POS_ID_HI    = 4'd3;
  localparam logic [POS_W-1:0] POS_PAY0     = 4'd4;
  localparam logic [POS_W-1:0] POS_RNG_HI   = 4'd6;
  localparam logic [POS_W-1:0] POS_RNG_LO   = 4'd7;
  localparam logic [POS_W-1:0] POS_PAY_LAST = 4'd10;
  localparam logic [POS_W-1:0] POS_CHECK    = 4'd11;

  typedef struct packed {
    logic        found;
    logic [15:0] distance;
  } rtfp_result_t;

endpackage

`default_nettype wire

/* design/rtfp_in_stage.sv */
// ----------------------------------------------------------------------------
// rtfp_in_stage
// Input register for received bytes; stalls when the parser cannot advance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtfp_in_stage
  import rtfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       out_free,
  output logic            byte_vld,
  output logic [7:0]      byte_val,
  output logic            proc_go
);

  logic       vld_r, vld_nxt;
  logic [7:0] byte_r;
  logic       accept;

  assign proc_go  = vld_r & out_free;
  assign in_stall = vld_r & ~out_free;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (proc_go) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_rx_byte;
    end
  end

  assign byte_vld = vld_r;
  assign byte_val = byte_r;

endmodule

`default_nettype wire

/* design/rtfp_parser.sv */
// ----------------------------------------------------------------------------
// rtfp_parser
// Frame hunt, checksum, target sequencing and running minimum of range minus offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "radar_target_frame_parser_unit_defines.svh"

module rtfp_parser
  import rtfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        go,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [15:0] range_offset,
  output logic             res_vld,
  output rtfp_result_t     res
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [15:0]      id_r, id_nxt;
  logic [7:0]       pay0_r, rng_hi_r, rng_lo_r;
  logic [7:0]       exp_r, exp_nxt;
  logic [7:0]       seen_r, seen_nxt;
  logic             minv_r, minv_nxt;
  logic [15:0]      mind_r, mind_nxt;

  logic [15:0] range_val;
  logic [15:0] diff;
  logic [8:0]  seen_inc;
  logic        in_seq;
  logic        take_min;

  assign range_val = {rng_hi_r, rng_lo_r};
  assign diff      = range_val - range_offset;
  assign seen_inc  = {1'b0, seen_r} + 9'd1;
  assign in_seq    = ({1'b0, pay0_r} == seen_inc) && (seen_r < exp_r);
  assign take_min  = (range_val > range_offset) && (!minv_r || diff < mind_r);

  always_comb begin
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    id_nxt   = id_r;
    exp_nxt  = exp_r;
    seen_nxt = seen_r;
    minv_nxt = minv_r;
    mind_nxt = mind_r;
    res_vld  = 1'b0;
    res      = '0;
    case (pos_r) inside
      POS_HDR0, POS_HDR1: begin
        sum_nxt = '0;
        // a bad header byte drops back without a second look
        pos_nxt = (rx_byte == SYNC_BYTE) ? pos_r + 4'd1 : POS_HDR0;
      end
      POS_ID_LO: begin
        id_nxt  = {id_r[15:8], rx_byte};
        pos_nxt = pos_r + 4'd1;
      end
      POS_ID_HI: begin
        id_nxt  = {rx_byte, id_r[7:0]};
        pos_nxt = pos_r + 4'd1;
      end
      [POS_PAY0:POS_PAY_LAST]: begin
        sum_nxt = sum_r + rx_byte;
        pos_nxt = pos_r + 4'd1;
      end
      default: begin
        pos_nxt = POS_HDR0;
        if (sum_r == rx_byte) begin
          if (id_r == ID_STATUS) begin
            exp_nxt  = pay0_r;
            seen_nxt = '0;
            minv_nxt = 1'b0;
            mind_nxt = '0;
            if (pay0_r == 8'd0) begin
              res_vld = 1'b1;
            end
          end else if (id_r == ID_TARGET) begin
            if (in_seq) begin
              seen_nxt = seen_inc[7:0];
              if (take_min) begin
                minv_nxt = 1'b1;
                mind_nxt = diff;
              end
              if (seen_inc[7:0] == exp_r) begin
                res_vld      = 1'b1;
                res.found    = minv_nxt;
                res.distance = minv_nxt ? mind_nxt : 16'd0;
              end
            end else begin
              exp_nxt  = '0;
              seen_nxt = '0;
            end
          end
        end
      end
    endcase
    res_vld = res_vld & go;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_HDR0;
      sum_r  <= '0;
      id_r   <= '0;
      exp_r  <= '0;
      seen_r <= '0;
      minv_r <= 1'b0;
      mind_r <= '0;
    end else if (go) begin
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      id_r   <= id_nxt;
      exp_r  <= exp_nxt;
      seen_r <= seen_nxt;
      minv_r <= minv_nxt;
      mind_r <= mind_nxt;
    end
  end

  // keep only the payload bytes that a frame decision reads
  always_ff @(posedge clk) begin
    if (go) begin
      if (pos_r == POS_PAY0) begin
        pay0_r <= rx_byte;
      end
      if (pos_r == POS_RNG_HI) begin
        rng_hi_r <= rx_byte;
      end
      if (pos_r == POS_RNG_LO) begin
        rng_lo_r <= rx_byte;
      end
    end
  end

  `RTFP_ASSERT(a_pos_range, clk, rst_n, pos_r <= POS_CHECK, "byte position past checksum")
  `RTFP_ASSERT(a_seen_le_exp, clk, rst_n, seen_r <= exp_r, "more targets seen than expected")
  `RTFP_ASSERT_IMPL(a_res_on_check, clk, rst_n, res_vld,
    go && pos_r == POS_CHECK && sum_r == rx_byte, "result off a valid checksum byte")
  `RTFP_ASSERT_IMPL(a_found_dist, clk, rst_n, res_vld && !res.found,
    res.distance == 16'd0, "no-target report with distance")

endmodule

`default_nettype wire

/* design/rtfp_out_stage.sv */
// ----------------------------------------------------------------------------
// rtfp_out_stage
// Result register; holds a report until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtfp_out_stage
  import rtfp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         go,
  input  wire logic         res_vld,
  input  wire rtfp_result_t res,
  output logic              out_free,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic              out_target_found,
  output logic [15:0]       out_nearest_distance
);

  logic         vld_r, vld_nxt;
  rtfp_result_t res_r;

  assign out_free = ~vld_r | ~out_stall;
  assign vld_nxt  = out_free ? (go & res_vld) : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res_vld) begin
      res_r <= res;
    end
  end

  assign out_valid            = vld_r;
  assign out_target_found     = res_r.found;
  assign out_nearest_distance = res_r.distance;

endmodule

`default_nettype wire

/* design/radar_target_frame_parser_unit.sv */
// ----------------------------------------------------------------------------
// radar_target_frame_parser_unit
// Hunts 12-byte radar frames in a byte stream and reports the nearest target.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  in_      | input     | in_valid/in_stall   | in_rx_byte[7:0]
//  out_     | output    | out_valid/out_stall | out_target_found, out_nearest_distance[15:0]
//  cfg_     | input     | cfg_valid/cfg_ready | cfg_range_offset[15:0]
//
//  One byte a cycle sustained unless out_stall holds a report in the result register.
//  The path is input register, one stage of parser logic, result register.
//  Synchronous active-low reset clears the hunt, target count and minimum.
//  range_offset resets to 0; cfg_ready is always high.
//  out_stall holds the report and backs up into in_stall in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module radar_target_frame_parser_unit
  import rtfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_target_found,
  output logic [15:0]      out_nearest_distance,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_range_offset
);

  logic [15:0]  offset_r;
  logic         out_free;
  logic         byte_vld;
  logic [7:0]   byte_val;
  logic         proc_go;
  logic         res_vld;
  rtfp_result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      offset_r <= cfg_range_offset;
    end
  end

  rtfp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .out_free   (out_free),
    .byte_vld   (byte_vld),
    .byte_val   (byte_val),
    .proc_go    (proc_go)
  );

  rtfp_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .go           (proc_go & byte_vld),
    .rx_byte      (byte_val),
    .range_offset (offset_r),
    .res_vld      (res_vld),
    .res          (res)
  );

  rtfp_out_stage u_out (
    .clk                  (clk),
    .rst_n                (rst_n),
    .go                   (proc_go),
    .res_vld              (res_vld),
    .res                  (res),
    .out_free             (out_free),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_target_found     (out_target_found),
    .out_nearest_distance (out_nearest_distance)
  );

endmodule

`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// Radar target frame parser testbench
// Streams radar frames byte by byte into the parser: target-status and
// target-info sequences with random content, other message ids, bad checksums,
// cut-short frames and stray bytes. A scoreboard follows the frame hunt, the
// target sequence and the running minimum, and checks every nearest-target
// report in order. The range offset is rewritten between phases with the
// block drained, and both sides of the stream stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import rtfp_pkg::*;

  localparam int unsigned STUCK_LIMIT  = 3000;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned SETTLE       = 6;
  localparam int unsigned PHASE_BYTES  = 120;

  typedef struct packed {
    logic        found;
    logic [15:0] gap;
  } nearest_report_t;

  class nearest_target_board;
    logic [15:0]     offset;
    logic [3:0]      pos;
    logic [15:0]     msg_id;
    logic [7:0]      pay [7];
    logic [7:0]      sum;
    logic [7:0]      want_targets;
    logic [7:0]      seen_targets;
    logic            min_ok;
    logic [15:0]     min_gap;
    nearest_report_t due_reports [$];
    int unsigned     fault_count;
    int unsigned     report_count;

    function new();
      offset       = '0;
      pos          = POS_HDR0;
      msg_id       = '0;
      sum          = '0;
      want_targets = '0;
      seen_targets = '0;
      min_ok       = 1'b0;
      min_gap      = '0;
      fault_count  = 0;
      report_count = 0;
      foreach (pay[i]) pay[i] = '0;
    endfunction

    function void set_offset(input logic [15:0] value);
      offset = value;
    endfunction

    // Advance the frame hunt by one accepted byte.
    function void take_byte(input logic [7:0] b);
      logic [15:0]     rng;
      logic [15:0]     d;
      nearest_report_t r;
      if (pos <= POS_HDR1) begin
        sum = '0;
        pos = (b == SYNC_BYTE) ? pos + 4'd1 : POS_HDR0;
      end else if (pos < POS_CHECK) begin
        if (pos == POS_ID_LO) begin
          msg_id[7:0] = b;
        end else if (pos == POS_ID_HI) begin
          msg_id[15:8] = b;
        end else begin
          pay[pos - POS_PAY0] = b;
          sum = sum + b;
        end
        pos = pos + 4'd1;
      end else begin
        pos = POS_HDR0;
        if (sum == b && msg_id == ID_STATUS) begin
          want_targets = pay[0];
          seen_targets = '0;
          min_ok       = 1'b0;
          min_gap      = '0;
          if (want_targets == 8'd0) begin
            r.found = 1'b0;
            r.gap   = '0;
            due_reports.push_back(r);
          end
        end else if (sum == b && msg_id == ID_TARGET) begin
          if ({1'b0, pay[0]} == {1'b0, seen_targets} + 9'd1 &&
              seen_targets < want_targets) begin
            seen_targets = seen_targets + 8'd1;
            rng = {pay[POS_RNG_HI - POS_PAY0], pay[POS_RNG_LO - POS_PAY0]};
            if (rng > offset) begin
              d = rng - offset;
              if (!min_ok || d < min_gap) begin
                min_gap = d;
                min_ok  = 1'b1;
              end
            end
            if (seen_targets == want_targets) begin
              r.found = min_ok;
              r.gap   = min_ok ? min_gap : 16'd0;
              due_reports.push_back(r);
            end
          end else begin
            // out of sequence: drop the count, keep the minimum flag
            want_targets = '0;
            seen_targets = '0;
          end
        end
      end
    endfunction

    function void match_report(input logic found, input logic [15:0] gap);
      nearest_report_t want;
      report_count++;
      if (due_reports.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("report %0d unexpected: found=%0b distance=%0d",
                   report_count, found, gap);
      end else begin
        want = due_reports.pop_front();
        if (found !== want.found || gap !== want.gap) begin
          fault_count++;
          if (fault_count <= 10)
            $display("report %0d: expected found=%0b distance=%0d, got found=%0b distance=%0d",
                     report_count, want.found, want.gap, found, gap);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_target_found;
  logic [15:0] out_nearest_distance;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_range_offset;

  nearest_target_board board;
  logic [15:0]         cur_offset;
  int unsigned         bytes_sent;
  int unsigned         quiet_cycles;
  bit                  no_idle;
  bit                  rx_calm;
  bit                  hold_req;

  radar_target_frame_parser_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_target_found     (out_target_found),
    .out_nearest_distance (out_nearest_distance),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_range_offset     (cfg_range_offset)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watch both channels and the config port; end the run when nothing moves.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.take_byte(in_rx_byte);
      if (out_valid && !out_stall) board.match_report(out_target_found, out_nearest_distance);
      if (cfg_valid && cfg_ready) board.set_offset(cfg_range_offset);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STUCK_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!rx_calm && !no_idle && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic [15:0] id, input logic [55:0] body,
                            input logic [7:0] sum_flip, input int keep);
    logic [7:0] chunk [12];
    logic [7:0] sum;
    sum      = '0;
    chunk[0] = SYNC_BYTE;
    chunk[1] = SYNC_BYTE;
    chunk[2] = id[7:0];
    chunk[3] = id[15:8];
    for (int i = 0; i < 7; i++) begin
      chunk[4 + i] = body[8*i +: 8];
      sum = sum + body[8*i +: 8];
    end
    chunk[11] = sum ^ sum_flip;
    for (int i = 0; i < keep; i++) push_byte(chunk[i]);
  endtask

  function automatic logic [55:0] rand_body(input logic [7:0] lead);
    return {16'($urandom()), 32'($urandom()), lead};
  endfunction

  function automatic logic [55:0] target_body(input logic [7:0] idx, input logic [15:0] rng);
    return {24'($urandom()), rng[7:0], rng[15:8], 8'($urandom()), idx};
  endfunction

  // Ranges cluster around the offset so both sides of the threshold are hit.
  function automatic logic [15:0] pick_range();
    case ($urandom_range(0, 7))
      0:       return cur_offset;
      1:       return cur_offset + 16'd1;
      2:       return cur_offset - 16'd1;
      3:       return 16'hFFFF;
      4:       return 16'h0000;
      5:       return 16'($urandom());
      default: return cur_offset + 16'($urandom_range(1, 3000));
    endcase
  endfunction

  task automatic send_noise();
    int unsigned len;
    case ($urandom_range(0, 4))
      0: begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) push_byte(8'($urandom()));
      end
      1: send_frame(16'($urandom()), rand_body(8'($urandom())), 8'h00, 12);
      2: send_frame($urandom_range(0, 1) ? ID_STATUS : ID_TARGET,
                    rand_body(8'($urandom_range(0, 2))), 8'($urandom_range(1, 255)), 12);
      3: send_frame(ID_TARGET, rand_body(8'd1), 8'h00, $urandom_range(1, 11));
      default: begin
        push_byte(SYNC_BYTE);
        push_byte(8'($urandom_range(0, 8'hA9)));
      end
    endcase
  endtask

  // One status frame and its target frames, now and then broken up.
  task automatic send_report();
    int unsigned pick;
    int unsigned n;
    int unsigned shown;
    logic [7:0]  idx;
    pick = $urandom_range(0, 19);
    if (pick < 3)       n = 0;
    else if (pick < 16) n = $urandom_range(1, 4);
    else if (pick < 19) n = $urandom_range(5, 8);
    else                n = $urandom_range(9, 255);
    send_frame(ID_STATUS, rand_body(8'(n)), 8'h00, 12);
    shown = (n > 8) ? 3 : n;
    for (int k = 1; k <= shown; k++) begin
      if ($urandom_range(0, 7) == 0) send_noise();
      idx = ($urandom_range(0, 14) == 0) ? 8'($urandom()) : 8'(k);
      send_frame(ID_TARGET, target_body(idx, pick_range()), 8'h00, 12);
    end
    if ($urandom_range(0, 11) == 0)
      send_frame(ID_TARGET, target_body(8'(shown + 1), pick_range()), 8'h00, 12);
  endtask

  task automatic write_offset(input logic [15:0] value);
    cfg_valid        <= 1'b1;
    cfg_range_offset <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    cur_offset = value;
  endtask

  // Stop sending and wait for every pending report, then let the pipe empty.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.due_reports.size() != 0) @(posedge clk);
    rx_calm = 1'b1;
    repeat (SETTLE) @(posedge clk);
    rx_calm = 1'b0;
  endtask

  initial begin
    int unsigned goal;
    logic [15:0] off;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_rx_byte       = '0;
    cfg_valid        = 1'b0;
    cfg_range_offset = '0;
    cur_offset       = '0;
    bytes_sent       = 0;
    quiet_cycles     = 0;
    no_idle          = 1'b0;
    rx_calm          = 1'b0;
    hold_req         = 1'b0;
    board            = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_offset(16'h0000);

    // zero-count status, broken header, then a one-target report at full range
    send_frame(ID_STATUS, 56'h0, 8'h00, 12);
    push_byte(SYNC_BYTE);
    push_byte(8'h55);
    send_frame(ID_STATUS, {48'hFFFF_FFFF_FFFF, 8'd1}, 8'h00, 12);
    send_frame(ID_TARGET, {24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF, 8'd1}, 8'h00, 12);

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0:       off = 16'hFFFF;
        1:       off = 16'($urandom());
        2:       off = 16'h0001;
        3:       off = 16'h8000;
        default: off = 16'($urandom_range(0, 16'h0FFF));
      endcase
      write_offset(off);
      if (ph == 2) begin
        // hold the result side while status frames keep coming
        no_idle  = 1'b0;
        hold_req = 1'b1;
        repeat (16) send_frame(ID_STATUS, rand_body(8'd0), 8'h00, 12);
      end
      goal = bytes_sent + PHASE_BYTES;
      while (bytes_sent < goal) begin
        no_idle = (ph == 4) || ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 5) == 0) send_noise();
        else send_report();
      end
    end
    drain();
    repeat (SETTLE) @(posedge clk);

    if (board.fault_count == 0 && board.due_reports.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/rtfp_pkg.sv
design/rtfp_in_stage.sv
design/rtfp_parser.sv
design/rtfp_out_stage.sv
design/radar_target_frame_parser_unit.sv
bench/testbench.sv
